// ===== hw/rtl/tli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg
// Shared constants, command and status types of the trajectory interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_JOINTS      = 6;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_TIME_WIDTH  = 32;

    localparam int FIELD_WIDTH = 32;
    localparam int STAMP_WIDTH = 32;
    localparam int JNUM_WIDTH  = 3;
    localparam int ALPHA_BITS  = 16;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_INTERP     = 2'd0;
    localparam logic [1:0] ST_CLAMP_LOW  = 2'd1;
    localparam logic [1:0] ST_CLAMP_HIGH = 2'd2;
    localparam logic [1:0] ST_TOO_FEW    = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic push;        // stage the incoming joint, commit if point_done
        logic clear;       // empty the ring
        logic query_load;  // latch query time
        logic seg_issue;   // read the time at the seg index
        logic seg_check;   // compare the read segment
        logic seg_next;    // advance segment index
        logic div_start;   // start the alpha division
        logic div_step;    // one alpha divider step
        logic val_issue;   // read both waypoints of the current joint
        logic val_mul;     // product stage
        logic val_out;     // load output register
        logic joint_next;  // advance joint index
    } tli_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic few_points;
        logic seg_hit;
        logic seg_last;
        logic div_done;
        logic joint_last;
        logic out_busy;
        logic commit_busy; // staged waypoint still being swept into the ring
    } tli_stat_t;

endpackage

// ===== hw/rtl/tli_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/tli_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_ctrl
// Sequencer for push, clear and query items of the trajectory interpolator.
// ----------------------------------------------------------------------------
module tli_ctrl
    import tli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [1:0] in_op,
    input  tli_stat_t  stat,
    output logic       in_ready,
    output tli_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FEW    = 4'd1;
    localparam logic [3:0] S_SEG_RD = 4'd2;
    localparam logic [3:0] S_SEG_CK = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_VAL_RD = 4'd5;
    localparam logic [3:0] S_VAL_WT = 4'd6;
    localparam logic [3:0] S_VAL_MU = 4'd7;
    localparam logic [3:0] S_VAL_OUT = 4'd8;
    localparam logic [3:0] S_START  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // hold off input while a committed waypoint is swept into the ring
    assign in_ready = (state_reg == S_IDLE) && !stat.commit_busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_op)
                        OP_PUSH:  cmd.push  = 1'b1;
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_QUERY:
                        begin
                            cmd.query_load = 1'b1;
                            state_next     = S_START;
                        end
                        default: ;
                    endcase
                end
            end
            S_START:
            begin
                state_next = stat.few_points ? S_FEW : S_SEG_RD;
            end
            S_FEW:
            begin
                if (!stat.out_busy)
                begin
                    cmd.val_out = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SEG_RD:
            begin
                cmd.seg_issue = 1'b1;
                state_next    = S_SEG_CK;
            end
            S_SEG_CK:
            begin
                cmd.seg_check = 1'b1;
                if (stat.seg_hit || stat.seg_last)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.seg_next = 1'b1;
                    state_next   = S_SEG_RD;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_VAL_RD;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_VAL_RD:
            begin
                cmd.val_issue = 1'b1;
                state_next    = S_VAL_WT;
            end
            S_VAL_WT:
            begin
                state_next = S_VAL_MU;
            end
            S_VAL_MU:
            begin
                cmd.val_mul = 1'b1;
                state_next  = S_VAL_OUT;
            end
            S_VAL_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.val_out = 1'b1;
                    if (stat.joint_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.joint_next = 1'b1;
                        state_next     = S_VAL_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/tli_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_datapath
// Waypoint ring, segment search, alpha divider and blend arithmetic.
// ----------------------------------------------------------------------------
module tli_datapath
    import tli_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int JOINTS      = DEF_JOINTS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tli_cmd_t                cmd,
    output tli_stat_t               stat,
    input  logic [STAMP_WIDTH-1:0]  in_time,
    input  logic [JNUM_WIDTH-1:0]   in_joint,
    input  logic                    in_done,
    input  logic [4*FIELD_WIDTH-1:0] in_values,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [JNUM_WIDTH-1:0]   out_joint,
    output logic [4*FIELD_WIDTH-1:0] out_values,
    output logic [1:0]              out_status,
    output logic                    out_last
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int VDEPTH = CAPACITY * JOINTS;
    localparam int VAW = $clog2(VDEPTH);
    localparam int RW = 4 * VALUE_WIDTH;
    localparam int DW = VALUE_WIDTH + 1;
    localparam int AW = ALPHA_BITS + 1;
    localparam int PW = DW + AW;
    localparam int TSW = (TIME_WIDTH < STAMP_WIDTH) ? TIME_WIDTH : STAMP_WIDTH;
    localparam int LW = $clog2(ALPHA_BITS + 1);

    // ring pointers
    logic [SW-1:0] wslot_reg;
    logic [CW-1:0] count_reg;
    logic [RW-1:0] staged_reg [JOINTS];
    logic [JW:0]   commit_reg;   // commit sweep index, JOINTS = idle

    logic [TSW-1:0] in_t;
    assign in_t = in_time[TSW-1:0];

    // time store
    logic          t_we;
    logic [SW-1:0] t_waddr, t_raddr;
    logic [TSW-1:0] t_rdata;

    // value store
    logic           v_we;
    logic [VAW-1:0] v_waddr, v_raddr;
    logic [RW-1:0]  v_rdata;

    // ring slot arithmetic: the sum stays below three times the capacity
    function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a,
                                               input logic [CW:0] b);
        logic [CW+SW:0] s;
        s = (CW+SW+1)'(a) + (CW+SW+1)'(b);
        if (s >= (CW+SW+1)'(CAPACITY))
        begin
            s = s - (CW+SW+1)'(CAPACITY);
        end
        if (s >= (CW+SW+1)'(CAPACITY))
        begin
            s = s - (CW+SW+1)'(CAPACITY);
        end
        return s[SW-1:0];
    endfunction

    logic [SW-1:0] oldest;
    assign oldest = slot_add(wslot_reg, (CW+1)'(CAPACITY) - (CW+1)'(count_reg));

    // commit: sweep staged joints into the value store one row per cycle
    logic commit_busy;
    assign commit_busy = (commit_reg != (JW+1)'(JOINTS));

    integer ji;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wslot_reg  <= '0;
            count_reg  <= '0;
            commit_reg <= (JW+1)'(JOINTS);
            for (ji = 0; ji < JOINTS; ji++)
            begin
                staged_reg[ji] <= '0;
            end
        end
        else
        begin
            if (commit_busy)
            begin
                commit_reg <= commit_reg + 1'b1;
                if (commit_reg == (JW+1)'(JOINTS - 1))
                begin
                    wslot_reg <= slot_add(wslot_reg, (CW+1)'(1));
                    if (count_reg != CW'(CAPACITY))
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
            end
            if (cmd.push)
            begin
                for (ji = 0; ji < JOINTS; ji++)
                begin
                    if (in_joint == JNUM_WIDTH'(ji))
                    begin
                        staged_reg[ji] <= {
                            VALUE_WIDTH'(in_values[3*FIELD_WIDTH +: FIELD_WIDTH]),
                            VALUE_WIDTH'(in_values[2*FIELD_WIDTH +: FIELD_WIDTH]),
                            VALUE_WIDTH'(in_values[1*FIELD_WIDTH +: FIELD_WIDTH]),
                            VALUE_WIDTH'(in_values[0 +: FIELD_WIDTH])};
                    end
                end
                if (in_done)
                begin
                    commit_reg <= '0;
                end
            end
            if (cmd.clear)
            begin
                wslot_reg <= '0;
                count_reg <= '0;
            end
        end
    end

    assign t_we    = cmd.push && in_done;
    assign t_waddr = wslot_reg;
    assign v_we    = commit_busy;
    assign v_waddr = VAW'(wslot_reg) * VAW'(JOINTS) + VAW'(commit_reg[JW-1:0] & {JW{1'b1}});

    logic [RW-1:0] commit_row;
    always_comb
    begin
        commit_row = staged_reg[0];
        for (int k = 0; k < JOINTS; k++)
        begin
            if (commit_reg[JW-1:0] == JW'(k))
            begin
                commit_row = staged_reg[k];
            end
        end
    end

    tli_ram #(.WIDTH(TSW), .DEPTH(CAPACITY)) u_time_ram (
        .clk     (clk),
        .wr_en   (t_we),
        .wr_addr (t_waddr),
        .wr_data (in_t),
        .rd_addr (t_raddr),
        .rd_data (t_rdata)
    );

    tli_ram #(.WIDTH(RW), .DEPTH(VDEPTH)) u_value_ram (
        .clk     (clk),
        .wr_en   (v_we),
        .wr_addr (v_waddr),
        .wr_data (commit_row),
        .rd_addr (v_raddr),
        .rd_data (v_rdata)
    );

    // segment search: time store read twice per segment would need two ports,
    // so keep the previous end time and read one new time per step
    logic [TSW-1:0] q_reg;
    logic [CW-1:0]  seg_reg;      // index of the time being read (0 = oldest)
    logic [TSW-1:0] prev_t_reg, first_t_reg;
    logic           have_prev_reg;
    logic [SW-1:0]  s0_reg, s1_reg;
    logic [1:0]     status_reg;
    logic           seg_hit_c, seg_last_c;
    logic [TSW-1:0] num_reg, den_reg;

    assign t_raddr = slot_add(oldest, (CW+1)'(seg_reg));
    assign seg_hit_c  = have_prev_reg && (prev_t_reg <= q_reg) && (q_reg <= t_rdata);
    assign seg_last_c = (seg_reg == count_reg - 1'b1);

    // divider
    logic [TSW:0]       rem_reg;
    logic [AW-1:0]      alpha_reg;
    logic [LW-1:0]      dcnt_reg;
    logic               ddone_reg;
    logic [TSW:0]       dgap;
    assign dgap = {1'b0, den_reg} - rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= '0;
            have_prev_reg <= 1'b0;
            ddone_reg     <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            if (cmd.query_load)
            begin
                seg_reg       <= '0;
                have_prev_reg <= 1'b0;
            end
            if (cmd.seg_check)
            begin
                prev_t_reg    <= t_rdata;
                have_prev_reg <= 1'b1;
                if (seg_reg == '0)
                begin
                    first_t_reg <= t_rdata;
                end
                if (seg_hit_c)
                begin
                    s0_reg     <= slot_add(oldest, (CW+1)'(seg_reg) - 1'b1 + (CW+1)'(CAPACITY));
                    s1_reg     <= t_raddr;
                    status_reg <= ST_INTERP;
                    num_reg    <= q_reg - prev_t_reg;
                    den_reg    <= t_rdata - prev_t_reg;
                end
                else
                begin
                    s0_reg  <= (q_reg < ((seg_reg == '0) ? t_rdata : first_t_reg)) ?
                               oldest : t_raddr;
                    s1_reg  <= (q_reg < ((seg_reg == '0) ? t_rdata : first_t_reg)) ?
                               oldest : t_raddr;
                    status_reg <= (q_reg < ((seg_reg == '0) ? t_rdata : first_t_reg)) ?
                                  ST_CLAMP_LOW : ST_CLAMP_HIGH;
                    num_reg <= '0;
                    den_reg <= '0;
                end
            end
            if (cmd.seg_next)
            begin
                seg_reg <= seg_reg + 1'b1;
            end
            if (cmd.div_start)
            begin
                ddone_reg <= 1'b0;
                dcnt_reg  <= '0;
            end
            if (ddone_reg == 1'b0 && cmd.div_step)
            begin
                if (dcnt_reg == '0)
                begin
                    rem_reg   <= {1'b0, num_reg};
                    alpha_reg <= '0;
                    if (den_reg == '0)
                    begin
                        ddone_reg <= 1'b1;
                    end
                    else if (num_reg >= den_reg)
                    begin
                        alpha_reg <= AW'(1) << ALPHA_BITS;
                        ddone_reg <= 1'b1;
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                else
                begin
                    if (rem_reg >= dgap)
                    begin
                        rem_reg   <= rem_reg - dgap;
                        alpha_reg <= {alpha_reg[AW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg   <= rem_reg << 1;
                        alpha_reg <= {alpha_reg[AW-2:0], 1'b0};
                    end
                    if (dcnt_reg == LW'(ALPHA_BITS))
                    begin
                        ddone_reg <= 1'b1;
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_load)
        begin
            q_reg <= in_t;
        end
    end

    // blend: read p0 then p1 over consecutive cycles from the one-port value store
    logic [JW-1:0] joint_reg;
    logic          rd_phase_reg;
    logic [RW-1:0] p0_reg;

    always_comb
    begin
        if (cmd.val_issue)
        begin
            v_raddr = VAW'(s0_reg) * VAW'(JOINTS) + VAW'(joint_reg);
        end
        else
        begin
            v_raddr = VAW'(s1_reg) * VAW'(JOINTS) + VAW'(joint_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint_reg    <= '0;
            rd_phase_reg <= 1'b0;
        end
        else
        begin
            rd_phase_reg <= cmd.val_issue;
            if (cmd.query_load)
            begin
                joint_reg <= '0;
            end
            if (cmd.joint_next)
            begin
                joint_reg <= joint_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_phase_reg)
        begin
            p0_reg <= v_rdata;
        end
    end

    // product stage: hi*alpha and lo*alpha per value, then add;
    // p1 comes straight from the value store read data in this cycle
    logic signed [VALUE_WIDTH-1:0] res_c [4];
    logic signed [PW-1:0] hi_reg [4];
    logic [ALPHA_BITS+AW-1:0] lo_reg [4];
    logic signed [VALUE_WIDTH-1:0] base_reg [4];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (cmd.val_mul)
            begin
                logic signed [DW-1:0] diff;
                diff = DW'($signed(v_rdata[k*VALUE_WIDTH +: VALUE_WIDTH]))
                     - DW'($signed(p0_reg[k*VALUE_WIDTH +: VALUE_WIDTH]));
                hi_reg[k]   <= PW'(diff >>> ALPHA_BITS) * $signed({1'b0, alpha_reg});
                lo_reg[k]   <= (ALPHA_BITS+AW)'(diff[ALPHA_BITS-1:0]) *
                               (ALPHA_BITS+AW)'(alpha_reg);
                base_reg[k] <= (alpha_reg[ALPHA_BITS]) ?
                               $signed(v_rdata[k*VALUE_WIDTH +: VALUE_WIDTH]) :
                               $signed(p0_reg[k*VALUE_WIDTH +: VALUE_WIDTH]);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (alpha_reg[ALPHA_BITS])
            begin
                res_c[k] = base_reg[k];
            end
            else
            begin
                res_c[k] = base_reg[k] + VALUE_WIDTH'(hi_reg[k])
                         + VALUE_WIDTH'(lo_reg[k] >> ALPHA_BITS);
            end
        end
    end

    // output register
    logic           ovalid_reg;
    logic [JNUM_WIDTH-1:0] ojoint_reg;
    logic [4*FIELD_WIDTH-1:0] ovalues_reg;
    logic [1:0]     ostatus_reg;
    logic           olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (cmd.val_out)
            begin
                ovalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.val_out)
        begin
            if (stat.few_points)
            begin
                ojoint_reg  <= '0;
                ovalues_reg <= '0;
                ostatus_reg <= ST_TOO_FEW;
                olast_reg   <= 1'b1;
            end
            else
            begin
                ojoint_reg  <= JNUM_WIDTH'(joint_reg);
                for (int k = 0; k < 4; k++)
                begin
                    ovalues_reg[k*FIELD_WIDTH +: FIELD_WIDTH] <= FIELD_WIDTH'(res_c[k]);
                end
                ostatus_reg <= status_reg;
                olast_reg   <= stat.joint_last;
            end
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_joint  = ojoint_reg;
    assign out_values = ovalues_reg;
    assign out_status = ostatus_reg;
    assign out_last   = olast_reg;

    assign stat.few_points  = (count_reg < CW'(2));
    assign stat.seg_hit     = seg_hit_c;
    assign stat.seg_last    = seg_last_c;
    assign stat.div_done    = ddone_reg;
    assign stat.joint_last  = (joint_reg == JW'(JOINTS - 1));
    assign stat.out_busy    = ovalid_reg && !out_ready;
    assign stat.commit_busy = commit_busy;

endmodule

// ===== hw/rtl/trajectory_linear_interpolator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_linear_interpolator_core
// Waypoint ring with linear blending between the waypoints around a query time.
// ----------------------------------------------------------------------------
// A push stages one joint; a push that commits a waypoint is followed by a
// commit sweep into the value store, one row per joint, during which input
// is held off. A query is accepted and started, then walks the ring, reading
// one stored waypoint time per step (one time-store read port), runs a
// bit-serial alpha division (quotient steps and a completion step) and
// blends each joint (the value store has one read port, so both waypoints are
// read in turn); output stalls hold it. Input is accepted only when no query
// is in progress and no commit sweep is running.
module trajectory_linear_interpolator_core
    import tli_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int JOINTS      = DEF_JOINTS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[1:0], time_stamp[33:2], joint_number[36:34], point_done[37],
    // position_in, velocity_in, acceleration_in, torque_in[165:38], zero fill
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // joint_out[2:0], position_out, velocity_out, acceleration_out,
    // torque_out[130:3], zero fill
    output logic [135:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // status
    output logic         m_axis_tlast
);

    tli_cmd_t  cmd;
    tli_stat_t stat;
    logic      in_fire;
    logic [4*FIELD_WIDTH-1:0] out_values;
    logic [JNUM_WIDTH-1:0]    out_joint;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    tli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_op    (s_axis_tdata[1:0]),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    tli_datapath #(
        .CAPACITY    (CAPACITY),
        .JOINTS      (JOINTS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_time    (s_axis_tdata[33:2]),
        .in_joint   (s_axis_tdata[36:34]),
        .in_done    (s_axis_tdata[37]),
        .in_values  (s_axis_tdata[165:38]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_joint  (out_joint),
        .out_values (out_values),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_values, out_joint};

endmodule
